[rtl/lru_page_replacement_macros.svh]
// Assertion macros used by the port-level checker of the LRU page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("LRU page replacement check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("LRU page replacement check failed");

`endif

[rtl/lrupr_pkg.sv]
// Package with the constants and types of the LRU page replacement block.
package lrupr_pkg;

    localparam int FRAMES        = 4;
    localparam int PAGE_WIDTH    = 16;
    localparam int FRAME_IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W        = FRAME_IDX_W;
    localparam int COUNT_W       = $clog2(FRAMES + 1);

    localparam int PAGE_NUM_W    = 16;
    localparam int FRAME_INDEX_W = 2;
    localparam int FAULT_W       = 16;
    localparam int CFG_W         = 3;
    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 3'd4;

    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int REG_IDX_W     = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;

    typedef enum logic {
        ST_EMPTY,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic drain;
    } dp_cmd_t;

endpackage

[rtl/lrupr_ctrl.sv]
// Handshake controller: tracks the output register and issues load commands to the datapath.
module lrupr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output lrupr_pkg::dp_cmd_t cmd
);
    import lrupr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.load   = 1'b0;
        cmd.drain  = 1'b0;
        case (state_reg)
            ST_EMPTY: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                m_valid = 1'b1;
                // The output register frees up in the same cycle its beat leaves.
                s_ready = m_ready;
                if (m_ready) begin
                    cmd.drain = 1'b1;
                    if (s_valid) begin
                        cmd.load = 1'b1;
                    end else begin
                        state_next = ST_EMPTY;
                    end
                end
            end
            default: begin
                state_next = ST_EMPTY;
            end
        endcase
    end

endmodule

[rtl/lrupr_dp.sv]
// Datapath: frame table, recency ranks, fault counter, config register and result register.
module lrupr_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lrupr_pkg::dp_cmd_t                    cmd,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lrupr_pkg::APB_DATA_W-1:0]      prdata,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]      s_page_number,
    output logic                                  m_hit,
    output logic                                  m_filled,
    output logic                                  m_replaced,
    output logic [lrupr_pkg::FRAME_INDEX_W-1:0]   m_frame_index,
    output logic [lrupr_pkg::PAGE_NUM_W-1:0]      m_victim_page,
    output logic [lrupr_pkg::FAULT_W-1:0]         m_fault_total
);
    import lrupr_pkg::*;

    logic [CFG_W-1:0]      frames_in_use_reg;
    logic [REG_IDX_W-1:0]  reg_idx;

    logic [PAGE_WIDTH-1:0] frame_page_reg [FRAMES];
    logic [FRAMES-1:0]     frame_valid_reg;
    logic [FRAMES-1:0]     frame_valid_next;
    logic [RANK_W-1:0]     rank_reg [FRAMES];
    logic [RANK_W-1:0]     rank_next [FRAMES];
    logic [FAULT_W-1:0]    fault_reg;
    logic [FAULT_W-1:0]    fault_next;

    logic [PAGE_WIDTH-1:0]  page;
    logic [FRAMES-1:0]      usable;
    logic [COUNT_W-1:0]     count;
    logic                   hit_found;
    logic [FRAME_IDX_W-1:0] hit_idx;
    logic                   empty_found;
    logic [FRAME_IDX_W-1:0] empty_idx;
    logic                   vic_found;
    logic [FRAME_IDX_W-1:0] vic_idx;
    logic [FRAME_IDX_W-1:0] sel_idx;
    logic [COUNT_W-1:0]     old_rank;

    logic                     hit_reg;
    logic                     filled_reg;
    logic                     replaced_reg;
    logic [FRAME_INDEX_W-1:0] frame_index_reg;
    logic [PAGE_NUM_W-1:0]    victim_page_reg;
    logic [PAGE_NUM_W-1:0]    victim_page_next;
    logic [FAULT_W-1:0]       fault_total_reg;

    // Configuration register.
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= CFG_FRAMES_RESET;
        end else if (psel && penable && pwrite && (reg_idx == REG_FRAMES_IN_USE)) begin
            frames_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_FRAMES_IN_USE) begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, frames_in_use_reg};
        end
    end

    // Lookup: all frames are compared in parallel.
    assign page = PAGE_WIDTH'(s_page_number);

    always_comb begin
        count       = '0;
        hit_found   = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        vic_found   = 1'b0;
        vic_idx     = '0;
        for (int i = 0; i < FRAMES; i++) begin
            // A limit of zero still allows frame 0; limits above FRAMES allow all.
            usable[i] = (i == 0) || (32'(i) < {{(32-CFG_W){1'b0}}, frames_in_use_reg});
            count     = count + COUNT_W'(frame_valid_reg[i]);
        end
        // Walk downward so the lowest-numbered match wins.
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (usable[i] && frame_valid_reg[i] && (frame_page_reg[i] == page)) begin
                hit_found = 1'b1;
                hit_idx   = FRAME_IDX_W'(i);
            end
            if (usable[i] && !frame_valid_reg[i]) begin
                empty_found = 1'b1;
                empty_idx   = FRAME_IDX_W'(i);
            end
        end
        for (int i = 0; i < FRAMES; i++) begin
            if (usable[i] && frame_valid_reg[i]
                && (!vic_found || (rank_reg[i] > rank_reg[vic_idx]))) begin
                vic_found = 1'b1;
                vic_idx   = FRAME_IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (hit_found) begin
            sel_idx  = hit_idx;
            old_rank = COUNT_W'(rank_reg[hit_idx]);
        end else if (empty_found) begin
            sel_idx  = empty_idx;
            old_rank = count;
        end else begin
            sel_idx  = vic_idx;
            old_rank = COUNT_W'(rank_reg[vic_idx]);
        end
    end

    // Recency update: the touched frame becomes rank zero and the valid frames
    // that were more recent than it age by one.
    always_comb begin
        frame_valid_next = frame_valid_reg;
        for (int i = 0; i < FRAMES; i++) begin
            rank_next[i] = rank_reg[i];
            if (FRAME_IDX_W'(i) == sel_idx) begin
                rank_next[i]        = '0;
                frame_valid_next[i] = 1'b1;
            end else if (frame_valid_reg[i] && (COUNT_W'(rank_reg[i]) < old_rank)) begin
                rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
        end
    end

    always_comb begin
        fault_next = fault_reg;
        if (!hit_found && (fault_reg != {FAULT_W{1'b1}})) begin
            fault_next = fault_reg + FAULT_W'(1);
        end
    end

    assign victim_page_next = (!hit_found && !empty_found)
                              ? PAGE_NUM_W'(frame_page_reg[vic_idx]) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_valid_reg <= '0;
            fault_reg       <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (cmd.load) begin
            frame_valid_reg <= frame_valid_next;
            fault_reg       <= fault_next;
            for (int i = 0; i < FRAMES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && !hit_found) begin
            frame_page_reg[sel_idx] <= page;
        end
    end

    // Result register; the controller holds its valid flag.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hit_reg         <= hit_found;
            filled_reg      <= !hit_found && empty_found;
            replaced_reg    <= !hit_found && !empty_found;
            frame_index_reg <= FRAME_INDEX_W'(sel_idx);
            victim_page_reg <= victim_page_next;
            fault_total_reg <= fault_next;
        end else if (cmd.drain) begin
            // Nothing new to show; clear the outcome flags of the beat just taken.
            hit_reg      <= 1'b0;
            filled_reg   <= 1'b0;
            replaced_reg <= 1'b0;
        end
    end

    assign m_hit         = hit_reg;
    assign m_filled      = filled_reg;
    assign m_replaced    = replaced_reg;
    assign m_frame_index = frame_index_reg;
    assign m_victim_page = victim_page_reg;
    assign m_fault_total = fault_total_reg;

endmodule

[rtl/lru_page_replacement.sv]
// Latency: a result beat is valid in the cycle after its page reference is accepted.
// Throughput: one reference per cycle while results are taken; the frame compares, victim pick and rank
// update all finish in that cycle, and the output register is refilled as it drains.
// Reset (aresetn low, synchronous): all frames empty, ranks and fault count zero,
// frames_in_use back to 4, no result pending.
// Top level of the LRU page replacement block.
module lru_page_replacement (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lrupr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]      s_page_number,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic                                  m_filled,
    output logic                                  m_replaced,
    output logic [lrupr_pkg::FRAME_INDEX_W-1:0]   m_frame_index,
    output logic [lrupr_pkg::PAGE_NUM_W-1:0]      m_victim_page,
    output logic [lrupr_pkg::FAULT_W-1:0]         m_fault_total
);
    import lrupr_pkg::*;

    dp_cmd_t cmd;

    assign pready = 1'b1;

    lrupr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lrupr_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .s_page_number (s_page_number),
        .m_hit         (m_hit),
        .m_filled      (m_filled),
        .m_replaced    (m_replaced),
        .m_frame_index (m_frame_index),
        .m_victim_page (m_victim_page),
        .m_fault_total (m_fault_total)
    );

endmodule

[rtl/lrupr_checker.sv]
// Port-level checker for the LRU page replacement block, bound to the top level.
`include "lru_page_replacement_macros.svh"

module lrupr_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic                                  m_hit,
    input logic                                  m_filled,
    input logic                                  m_replaced,
    input logic [lrupr_pkg::FRAME_INDEX_W-1:0]   m_frame_index,
    input logic [lrupr_pkg::PAGE_NUM_W-1:0]      m_victim_page,
    input logic [lrupr_pkg::FAULT_W-1:0]         m_fault_total
);
    import lrupr_pkg::*;

    // A stalled result beat keeps its payload.
    `LRUPR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_hit) && $stable(m_frame_index) && $stable(m_victim_page) && $stable(m_fault_total))

    // Every result reports exactly one outcome.
    `LRUPR_ASSERT_NOW(a_one_outcome, aclk, aresetn, m_valid, $onehot({m_hit, m_filled, m_replaced}))

    // Only an eviction reports a victim page.
    `LRUPR_ASSERT_NOW(a_victim_zero, aclk, aresetn, m_valid && !m_replaced, m_victim_page == '0)

    // With nothing waiting at the output the block takes a reference.
    `LRUPR_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // An accepted reference shows up as a result in the next cycle.
    `LRUPR_ASSERT_NEXT(a_one_cycle, aclk, aresetn, s_valid && s_ready, m_valid)

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);

[tb/lru_page_replacement_check.sv]
// Predictor and result comparison for the LRU page replacement testbench.
module lru_page_replacement_check (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic                                  pready,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0]      pwdata,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]      s_page_number,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic                                  m_hit,
    input  logic                                  m_filled,
    input  logic                                  m_replaced,
    input  logic [lrupr_pkg::FRAME_INDEX_W-1:0]   m_frame_index,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]      m_victim_page,
    input  logic [lrupr_pkg::FAULT_W-1:0]         m_fault_total,
    output int                                    mismatch_count,
    output int                                    refs_in_flight
);
    import lrupr_pkg::*;

    typedef struct packed {
        logic                     hit;
        logic                     filled;
        logic                     replaced;
        logic [FRAME_INDEX_W-1:0] frame;
        logic [PAGE_NUM_W-1:0]    victim;
        logic [FAULT_W-1:0]       faults;
    } lru_outcome_t;

    logic [PAGE_NUM_W-1:0] held_page    [FRAMES];
    logic                  frame_loaded [FRAMES];
    logic [RANK_W-1:0]     age_rank     [FRAMES];
    logic [FAULT_W-1:0]    fault_count;
    logic [CFG_W-1:0]      frames_setting;
    lru_outcome_t          outcome_q [$];

    // Make frame f the most recent; loaded frames newer than old_rank age by one.
    function automatic void promote_frame(input int f, input int old_rank);
        int i;
        for (i = 0; i < FRAMES; i++) begin
            if (i != f && frame_loaded[i] && age_rank[i] < old_rank)
                age_rank[i] = age_rank[i] + 1'b1;
        end
        age_rank[f] = '0;
    endfunction

    function automatic lru_outcome_t resolve_reference(input logic [PAGE_NUM_W-1:0] page);
        lru_outcome_t r;
        int i, limit, slot, empty_slot, oldest, loaded;
        r = '0;
        limit = (frames_setting == 0) ? 1 :
                (frames_setting > FRAMES) ? FRAMES : int'(frames_setting);
        slot = -1;
        empty_slot = -1;
        oldest = -1;
        loaded = 0;
        for (i = 0; i < FRAMES; i++)
            if (frame_loaded[i]) loaded++;
        // Frames at or above the limit keep their pages but are not searched.
        for (i = 0; i < limit; i++) begin
            if (frame_loaded[i]) begin
                if (slot < 0 && held_page[i] == page) slot = i;
                if (oldest < 0) oldest = i;
                else if (age_rank[i] > age_rank[oldest]) oldest = i;
            end else if (empty_slot < 0) begin
                empty_slot = i;
            end
        end
        if (slot >= 0) begin
            r.hit = 1'b1;
            promote_frame(slot, age_rank[slot]);
        end else begin
            if (fault_count != '1) fault_count = fault_count + 1'b1;
            if (empty_slot >= 0) begin
                r.filled = 1'b1;
                slot = empty_slot;
                frame_loaded[slot] = 1'b1;
                held_page[slot] = page;
                // A new frame starts older than every loaded one, so all of them age.
                promote_frame(slot, loaded);
            end else begin
                r.replaced = 1'b1;
                slot = oldest;
                r.victim = held_page[slot];
                held_page[slot] = page;
                promote_frame(slot, age_rank[slot]);
            end
        end
        r.frame = slot[FRAME_INDEX_W-1:0];
        r.faults = fault_count;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [PAGE_NUM_W-1:0] want,
                               input logic [PAGE_NUM_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        lru_outcome_t want;
        int i;
        if (!aresetn) begin
            for (i = 0; i < FRAMES; i++) begin
                frame_loaded[i] = 1'b0;
                age_rank[i] = '0;
            end
            fault_count = '0;
            frames_setting = CFG_FRAMES_RESET;
            outcome_q.delete();
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_FRAMES_IN_USE)
                frames_setting = pwdata[CFG_W-1:0];
            // A result beat always comes after its reference is accepted, so compare first.
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat arrived with no page reference waiting");
                    mismatch_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("hit", PAGE_NUM_W'(want.hit), PAGE_NUM_W'(m_hit));
                    check_field("filled", PAGE_NUM_W'(want.filled), PAGE_NUM_W'(m_filled));
                    check_field("replaced", PAGE_NUM_W'(want.replaced),
                                PAGE_NUM_W'(m_replaced));
                    check_field("frame_index", PAGE_NUM_W'(want.frame),
                                PAGE_NUM_W'(m_frame_index));
                    check_field("victim_page", want.victim, m_victim_page);
                    check_field("fault_total", PAGE_NUM_W'(want.faults),
                                PAGE_NUM_W'(m_fault_total));
                end
            end
            if (s_valid && s_ready) begin
                want = resolve_reference(s_page_number);
                outcome_q = {outcome_q, want};
            end
        end
        refs_in_flight = outcome_q.size();
    end

endmodule

[tb/lru_page_replacement_tb.sv]
// Top of the LRU page replacement testbench: clock, reset, stimulus and verdict.
module lru_page_replacement_tb;
    import lrupr_pkg::*;

    localparam int CYCLE_LIMIT   = 20000;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0]    pwdata = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [PAGE_NUM_W-1:0]    s_page_number = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_hit;
    logic                     m_filled;
    logic                     m_replaced;
    logic [FRAME_INDEX_W-1:0] m_frame_index;
    logic [PAGE_NUM_W-1:0]    m_victim_page;
    logic [FAULT_W-1:0]       m_fault_total;

    int                       mismatch_count;
    int                       refs_in_flight;
    int                       cycle_count = 0;
    logic                     allow_gaps = 1'b1;
    logic [PAGE_NUM_W-1:0]    page_pool [6];

    lru_page_replacement dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_page_number(s_page_number),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_filled(m_filled),
        .m_replaced(m_replaced), .m_frame_index(m_frame_index),
        .m_victim_page(m_victim_page), .m_fault_total(m_fault_total)
    );

    lru_page_replacement_check frame_check (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_page_number(s_page_number),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_filled(m_filled),
        .m_replaced(m_replaced), .m_frame_index(m_frame_index),
        .m_victim_page(m_victim_page), .m_fault_total(m_fault_total),
        .mismatch_count(mismatch_count), .refs_in_flight(refs_in_flight)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= allow_gaps ? ($urandom_range(99) >= 7) : 1'b1;
    end

    // Entered and left at a falling edge; valid stays high after the beat is taken.
    task automatic send_page(input logic [PAGE_NUM_W-1:0] page);
        while (allow_gaps && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            s_page_number <= PAGE_NUM_W'($urandom);
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_page_number <= page;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Hold off new references until every outstanding result has drained.
    task automatic settle();
        s_valid <= 1'b0;
        while (refs_in_flight != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word = APB_DATA_W'($urandom);
        word[CFG_W-1:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_FRAMES_IN_USE, 2'b00};
        pwdata <= word;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin : stimulus
        int n, phase;
        logic [PAGE_NUM_W-1:0] page;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill all four frames from reset, hit twice, then evict the oldest pages.
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'hA5A5);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h5A5A);
        send_page(16'h1234);

        // Shrink while loaded: the page left in frame 3 must miss and reload below.
        settle();
        write_frames_in_use(3'd2);
        send_page(16'h1234);
        send_page(16'h0000);
        send_page(16'h5A5A);

        // A setting of zero behaves as a single frame.
        settle();
        write_frames_in_use(3'd0);
        send_page(16'h1234);
        send_page(16'hBEEF);
        send_page(16'hBEEF);

        // Settings above the frame count act as the full set; stale copies reappear.
        settle();
        write_frames_in_use(3'd7);
        send_page(16'h1234);
        send_page(16'h5A5A);
        send_page(16'h8001);
        send_page(16'hBEEF);
        settle();
        write_frames_in_use(3'd5);
        send_page(16'h7FFE);
        send_page(16'h0000);

        // Random phases over every setting, mostly drawn from a small working set.
        for (phase = 0; phase < 8; phase++) begin
            settle();
            write_frames_in_use(phase[CFG_W-1:0]);
            allow_gaps <= (phase != 4);
            foreach (page_pool[k]) page_pool[k] = PAGE_NUM_W'($urandom);
            for (n = 0; n < 50; n++) begin
                if ($urandom_range(99) < 80)
                    page = page_pool[$urandom_range((phase % 4) + 2)];
                else
                    page = PAGE_NUM_W'($urandom);
                send_page(page);
            end
        end

        settle();
        write_frames_in_use(CFG_FRAMES_RESET);
        allow_gaps <= 1'b1;
        for (n = 0; n < 30; n++)
            send_page(page_pool[$urandom_range(5)]);

        settle();
        repeat (3) @(negedge aclk);
        if (mismatch_count == 0 && refs_in_flight == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
